// File: hw/rtl/rci_pkg.sv
// Shared constants for the ray / cylinder intersection block.
`default_nettype none
package rci_pkg;
   localparam int COORD_WIDTH = 32;
   localparam int DIGIT_W     = 16;
   localparam int CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CYL_RADIUS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CYL_LENGTH = 3'd4;
endpackage
`default_nettype wire

// File: hw/rtl/rci_req_if.sv
// Ray request channel: valid/ready plus ray origin and direction.
`default_nettype none
interface rci_req_if #(
   parameter int CW = rci_pkg::COORD_WIDTH
) ();
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] ray_origin_x;
   logic signed [CW-1:0] ray_origin_y;
   logic signed [CW-1:0] ray_origin_z;
   logic signed [CW-1:0] ray_dir_x;
   logic signed [CW-1:0] ray_dir_y;
   logic signed [CW-1:0] ray_dir_z;

   modport source (output valid, ray_origin_x, ray_origin_y, ray_origin_z,
                   ray_dir_x, ray_dir_y, ray_dir_z, input ready);
   modport sink   (input valid, ray_origin_x, ray_origin_y, ray_origin_z,
                   ray_dir_x, ray_dir_y, ray_dir_z, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rci_rsp_if.sv
// Intersection result channel: valid/ready plus hit flag and hit point.
`default_nettype none
interface rci_rsp_if #(
   parameter int CW = rci_pkg::COORD_WIDTH
) ();
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic signed [CW-1:0] hit_x;
   logic signed [CW-1:0] hit_y;
   logic signed [CW-1:0] hit_z;

   modport source (output valid, hit, hit_x, hit_y, hit_z, input ready);
   modport sink   (input valid, hit, hit_x, hit_y, hit_z, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rci_mul.sv
// Pipelined signed multiplier, one digit of the second operand per stage.
`default_nettype none
module rci_mul #(
   parameter int WA = rci_pkg::COORD_WIDTH,
   parameter int WB = rci_pkg::COORD_WIDTH,
   parameter int TW = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [TW-1:0]           in_tag,
   input  logic signed [WA-1:0]    op_a,
   input  logic signed [WB-1:0]    op_b,
   output logic                    out_valid,
   output logic [TW-1:0]           out_tag,
   output logic signed [WA+WB-1:0] prod
);
   localparam int DW = rci_pkg::DIGIT_W;
   localparam int ND = (WB + DW - 1) / DW;
   localparam int BW = ND * DW;
   localparam int PW = WA + WB;

   logic [WA-1:0]         amag;
   logic [WB-1:0]         bmag;
   logic [ND:0]           v_ff;
   logic [ND:0]           neg_ff;
   logic [TW-1:0]         tag_ff [ND+1];
   logic [WA-1:0]         am_ff [ND];
   logic [BW-1:0]         bm_ff [ND];
   logic [PW-1:0]         acc_ff [1:ND];
   logic                  ov_ff;
   logic [TW-1:0]         otag_ff;
   logic signed [PW-1:0]  prod_ff;

   assign amag = op_a[WA-1] ? unsigned'(-op_a) : unsigned'(op_a);
   assign bmag = op_b[WB-1] ? unsigned'(-op_b) : unsigned'(op_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         am_ff[0]  <= amag;
         bm_ff[0]  <= BW'(bmag);
         neg_ff[0] <= op_a[WA-1] ^ op_b[WB-1];
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar k = 1; k <= ND; k++) begin : g_acc
      logic [WA+DW-1:0] part;
      logic [PW-1:0]    base;

      assign part = {{DW{1'b0}}, am_ff[k-1]} * {{WA{1'b0}}, bm_ff[k-1][(k-1)*DW +: DW]};

      if (k == 1) begin : g_first
         assign base = '0;
      end else begin : g_next
         assign base = acc_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= base + (PW'(part) << ((k-1) * DW));
            neg_ff[k] <= neg_ff[k-1];
            tag_ff[k] <= tag_ff[k-1];
         end
      end

      if (k < ND) begin : g_pass
         always_ff @(posedge clock) begin
            if (en) begin
               am_ff[k] <= am_ff[k-1];
               bm_ff[k] <= bm_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= v_ff[ND];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= neg_ff[ND] ? -$signed(acc_ff[ND]) : $signed(acc_ff[ND]);
         otag_ff <= tag_ff[ND];
      end
   end

   assign out_valid = ov_ff;
   assign out_tag   = otag_ff;
   assign prod      = prod_ff;
endmodule
`default_nettype wire

// File: hw/rtl/rci_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module rci_isqrt #(
   parameter int RW = 4 * rci_pkg::COORD_WIDTH + 2,
   parameter int TW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [TW-1:0]    in_tag,
   input  logic [RW-1:0]    radicand,
   output logic             out_valid,
   output logic [TW-1:0]    out_tag,
   output logic [RW/2-1:0]  root
);
   localparam int SW  = RW / 2;
   localparam int RMW = SW + 3;

   logic [SW-1:0]   v_ff;
   logic [TW-1:0]   tag_ff  [SW];
   logic [RW-1:0]   rad_ff  [SW];
   logic [SW-1:0]   root_ff [SW];
   logic [RMW-1:0]  rem_ff  [SW];

   for (genvar k = 0; k < SW; k++) begin : g_stage
      logic            p_v;
      logic [TW-1:0]   p_tag;
      logic [RW-1:0]   p_rad;
      logic [SW-1:0]   p_root;
      logic [RMW-1:0]  p_rem;
      logic [RMW-1:0]  cur;
      logic [RMW-1:0]  trial;
      logic            take;

      if (k == 0) begin : g_first
         assign p_v    = in_valid;
         assign p_tag  = in_tag;
         assign p_rad  = radicand;
         assign p_root = '0;
         assign p_rem  = '0;
      end else begin : g_next
         assign p_v    = v_ff[k-1];
         assign p_tag  = tag_ff[k-1];
         assign p_rad  = rad_ff[k-1];
         assign p_root = root_ff[k-1];
         assign p_rem  = rem_ff[k-1];
      end

      assign cur   = {p_rem[RMW-3:0], p_rad[RW-1 -: 2]};
      assign trial = RMW'({p_root, 2'b01});
      assign take  = (cur >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= p_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? cur - trial : cur;
            root_ff[k] <= {p_root[SW-2:0], take};
            rad_ff[k]  <= p_rad << 2;
            tag_ff[k]  <= p_tag;
         end
      end
   end

   assign out_valid = v_ff[SW-1];
   assign out_tag   = tag_ff[SW-1];
   assign root      = root_ff[SW-1];
endmodule
`default_nettype wire

// File: hw/rtl/rci_div.sv
// Pipelined restoring divider, signed numerator by unsigned divisor, truncating.
`default_nettype none
module rci_div #(
   parameter int NUMW = 3 * rci_pkg::COORD_WIDTH + 3,
   parameter int DVW  = 2 * rci_pkg::COORD_WIDTH,
   parameter int TW   = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [TW-1:0]         in_tag,
   input  logic signed [NUMW-1:0] numer,
   input  logic [DVW-1:0]        denom,
   output logic                  out_valid,
   output logic [TW-1:0]         out_tag,
   output logic signed [NUMW:0]  quot
);
   logic [NUMW-1:0]      nmag;
   logic [NUMW:0]        v_ff;
   logic [NUMW:0]        neg_ff;
   logic [TW-1:0]        tag_ff [NUMW+1];
   logic [NUMW-1:0]      nq_ff  [NUMW+1];
   logic [DVW-1:0]       rem_ff [NUMW+1];
   logic [DVW-1:0]       d_ff   [NUMW];
   logic                 ov_ff;
   logic [TW-1:0]        otag_ff;
   logic signed [NUMW:0] quot_ff;

   assign nmag = numer[NUMW-1] ? unsigned'(-numer) : unsigned'(numer);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nq_ff[0]  <= nmag;
         rem_ff[0] <= '0;
         d_ff[0]   <= denom;
         neg_ff[0] <= numer[NUMW-1];
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar k = 1; k <= NUMW; k++) begin : g_step
      logic [DVW:0] cur;
      logic [DVW:0] dext;
      logic         take;

      assign cur  = {rem_ff[k-1], nq_ff[k-1][NUMW-1]};
      assign dext = {1'b0, d_ff[k-1]};
      assign take = (cur >= dext);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= take ? DVW'(cur - dext) : DVW'(cur);
            nq_ff[k]  <= {nq_ff[k-1][NUMW-2:0], take};
            neg_ff[k] <= neg_ff[k-1];
            tag_ff[k] <= tag_ff[k-1];
         end
      end

      if (k < NUMW) begin : g_pass
         always_ff @(posedge clock) begin
            if (en) begin
               d_ff[k] <= d_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= v_ff[NUMW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= neg_ff[NUMW] ? -$signed({1'b0, nq_ff[NUMW]}) : $signed({1'b0, nq_ff[NUMW]});
         otag_ff <= tag_ff[NUMW];
      end
   end

   assign out_valid = ov_ff;
   assign out_tag   = otag_ff;
   assign quot      = quot_ff;
endmodule
`default_nettype wire

// File: hw/rtl/ray_cylinder_intersect.sv
// Pipeline order from request beat to response beat at COORD_WIDTH 32: 3 front stages,
//   the h*h and a*c multipliers, S4, the square root, S5, the D*n multipliers, the dividers, S6, output.
// Throughput: one ray per cycle; the whole pipeline advances together and
//   freezes only while a response beat is held unaccepted at the output register.
// Reset: synchronous, clears all valid bits and the cylinder registers to zero.
`default_nettype none
module ray_cylinder_intersect #(
   parameter int COORD_WIDTH = rci_pkg::COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   rci_req_if.sink                       req,
   rci_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [rci_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [COORD_WIDTH-1:0]        csr_wdata
);
   // Exact widths of every intermediate, all derived from the coordinate width.
   localparam int W   = COORD_WIDTH;
   localparam int EW  = W + 1;          // origin minus axis
   localparam int AW  = 2 * W + 1;      // a = Dx^2 + Dy^2
   localparam int HW  = 2 * W + 2;      // h = Dx*Ex + Dy*Ey
   localparam int KW  = 2 * W + 3;      // c = Ex^2 + Ey^2 - r^2
   localparam int QW  = 2 * KW + 1;     // quarter discriminant
   localparam int RW  = 4 * W + 2;      // radicand bits (positive Q fits)
   localparam int SW  = RW / 2;         // root bits
   localparam int NW  = 2 * W + 3;      // root numerator n
   localparam int DNW = NW + W;         // D*n
   localparam int QTW = DNW + 1;        // D*n/a
   localparam int PPW = QTW + 1;        // hit point, unsaturated
   localparam int ZW  = PPW + 1;        // z span differences
   localparam int DVW = 2 * W;          // divisor a as unsigned

   localparam logic signed [PPW-1:0] PMAX = PPW'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [PPW-1:0] PMIN = -PMAX - 1;

   typedef struct packed {
      logic signed [W-1:0] ox;
      logic signed [W-1:0] oy;
      logic signed [W-1:0] oz;
      logic signed [W-1:0] dx;
      logic signed [W-1:0] dy;
      logic signed [W-1:0] dz;
   } ray_type;

   typedef struct packed {
      logic                 dirz;
      logic signed [AW-1:0] a;
      logic signed [HW-1:0] h;
   } quad_type;

   typedef struct packed {
      logic                 dirz;
      logic                 qneg;
      logic                 qzero;
      logic signed [AW-1:0] a;
      logic signed [HW-1:0] h;
      ray_type              ray;
   } root_tag_type;

   typedef struct packed {
      logic                 miss;
      logic signed [AW-1:0] a;
   } mx_tag_type;

   typedef struct packed {
      logic signed [W-1:0] oy;
      logic signed [W-1:0] oz;
   } yz_type;

   typedef struct packed {
      logic signed [W-1:0] ox;
      logic signed [W-1:0] oy;
   } xy_type;

   function automatic logic signed [W-1:0] sat(input logic signed [PPW-1:0] p);
      logic signed [W-1:0] r;
      priority if (p > PMAX) begin
         r = {1'b0, {(W-1){1'b1}}};
      end else if (p < PMIN) begin
         r = {1'b1, {(W-1){1'b0}}};
      end else begin
         r = p[W-1:0];
      end
      return r;
   endfunction

   // ---------------- configuration registers ----------------
   logic signed [W-1:0] cx_ff, cy_ff, bz_ff;
   logic [W-2:0]        rad_ff, len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         bz_ff  <= '0;
         rad_ff <= '0;
         len_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx)
            rci_pkg::CSR_CENTER_X:   cx_ff  <= csr_wdata;
            rci_pkg::CSR_CENTER_Y:   cy_ff  <= csr_wdata;
            rci_pkg::CSR_BASE_Z:     bz_ff  <= csr_wdata;
            rci_pkg::CSR_CYL_RADIUS: rad_ff <= csr_wdata[W-2:0];
            rci_pkg::CSR_CYL_LENGTH: len_ff <= csr_wdata[W-2:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // Global advance: every stage moves unless the output beat is stuck.
   logic adv;
   logic out_v_ff;
   assign adv       = !out_v_ff || rsp.ready;
   assign req.ready = adv;

   // ---------------- S1: capture ray, offset from axis ----------------
   logic                 s1_v_ff, s1_dirz_ff;
   ray_type              s1_ray_ff;
   logic signed [EW-1:0] s1_ex_ff, s1_ey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ray_ff  <= '{req.ray_origin_x, req.ray_origin_y, req.ray_origin_z,
                         req.ray_dir_x, req.ray_dir_y, req.ray_dir_z};
         s1_ex_ff   <= EW'(req.ray_origin_x) - EW'(cx_ff);
         s1_ey_ff   <= EW'(req.ray_origin_y) - EW'(cy_ff);
         s1_dirz_ff <= (req.ray_dir_x == '0) && (req.ray_dir_y == '0);
      end
   end

   // ---------------- S2: narrow squares and cross terms ----------------
   logic                    s2_v_ff, s2_dirz_ff;
   ray_type                 s2_ray_ff;
   logic signed [2*W-1:0]   s2_dxdx_ff, s2_dydy_ff;
   logic signed [W+EW-1:0]  s2_dxex_ff, s2_dyey_ff;
   logic signed [2*EW-1:0]  s2_exex_ff, s2_eyey_ff;
   logic [2*W-3:0]          s2_rr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ray_ff  <= s1_ray_ff;
         s2_dirz_ff <= s1_dirz_ff;
         s2_dxdx_ff <= s1_ray_ff.dx * s1_ray_ff.dx;
         s2_dydy_ff <= s1_ray_ff.dy * s1_ray_ff.dy;
         s2_dxex_ff <= s1_ray_ff.dx * s1_ex_ff;
         s2_dyey_ff <= s1_ray_ff.dy * s1_ey_ff;
         s2_exex_ff <= s1_ex_ff * s1_ex_ff;
         s2_eyey_ff <= s1_ey_ff * s1_ey_ff;
         s2_rr_ff   <= rad_ff * rad_ff;
      end
   end

   // ---------------- S3: quadratic coefficients a, h, c ----------------
   logic                 s3_v_ff;
   quad_type             s3_quad_ff;
   ray_type              s3_ray_ff;
   logic signed [KW-1:0] s3_c_ff;
   quad_type             quad_in;
   logic signed [KW-1:0] c_in;

   always_comb begin
      quad_in.dirz = s2_dirz_ff;
      quad_in.a    = AW'(s2_dxdx_ff) + AW'(s2_dydy_ff);
      quad_in.h    = HW'(s2_dxex_ff) + HW'(s2_dyey_ff);
      c_in         = KW'(s2_exex_ff) + KW'(s2_eyey_ff) - $signed(KW'(s2_rr_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_quad_ff <= quad_in;
         s3_ray_ff  <= s2_ray_ff;
         s3_c_ff    <= c_in;
      end
   end

   // ---------------- h*h and a*c, wide multipliers ----------------
   logic                   m1_hv, m1_cv;
   quad_type               m1_quad;
   ray_type                m1_ray;
   logic signed [2*KW-1:0] m1_hh, m1_ac;

   rci_mul #(.WA(KW), .WB(KW), .TW($bits(quad_type))) u_mul_hh (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s3_v_ff),
      .in_tag    (s3_quad_ff),
      .op_a      (KW'(s3_quad_ff.h)),
      .op_b      (KW'(s3_quad_ff.h)),
      .out_valid (m1_hv),
      .out_tag   (m1_quad),
      .prod      (m1_hh)
   );

   rci_mul #(.WA(KW), .WB(KW), .TW($bits(ray_type))) u_mul_ac (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s3_v_ff),
      .in_tag    (s3_ray_ff),
      .op_a      (s3_c_ff),
      .op_b      (KW'(s3_quad_ff.a)),
      .out_valid (m1_cv),
      .out_tag   (m1_ray),
      .prod      (m1_ac)
   );

   // ---------------- S4: discriminant and its sign ----------------
   logic                 s4_v_ff;
   root_tag_type         s4_tag_ff;
   logic [RW-1:0]        s4_rad_ff;
   logic signed [QW-1:0] q_in;

   assign q_in = QW'(m1_hh) - QW'(m1_ac);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= m1_hv && m1_cv;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_tag_ff.dirz  <= m1_quad.dirz;
         s4_tag_ff.qneg  <= q_in[QW-1];
         s4_tag_ff.qzero <= (q_in == '0);
         s4_tag_ff.a     <= m1_quad.a;
         s4_tag_ff.h     <= m1_quad.h;
         s4_tag_ff.ray   <= m1_ray;
         // Only a positive discriminant needs its root.
         s4_rad_ff       <= (q_in[QW-1] || q_in == '0) ? '0 : q_in[RW-1:0];
      end
   end

   // ---------------- floor square root ----------------
   logic          sq_v;
   root_tag_type  sq_tag;
   logic [SW-1:0] sq_root;

   rci_isqrt #(.RW(RW), .TW($bits(root_tag_type))) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s4_v_ff),
      .in_tag    (s4_tag_ff),
      .radicand  (s4_rad_ff),
      .out_valid (sq_v),
      .out_tag   (sq_tag),
      .root      (sq_root)
   );

   // ---------------- S5: root choice ----------------
   logic                 s5_v_ff, s5_miss_ff;
   logic signed [NW-1:0] s5_n_ff;
   logic signed [AW-1:0] s5_a_ff;
   ray_type              s5_ray_ff;
   logic signed [NW-1:0] nh, sx, n1, n2, n_in;
   logic                 miss_in;

   always_comb begin
      nh = -NW'(sq_tag.h);
      sx = $signed(NW'(sq_root));
      n1 = nh - sx;
      n2 = nh + sx;
      // Tangent ray takes -h with no sign check; otherwise nearer positive root.
      priority if (sq_tag.qzero) begin
         n_in = nh;
      end else if (n1 > 0) begin
         n_in = n1;
      end else begin
         n_in = n2;
      end
      miss_in = sq_tag.dirz || sq_tag.qneg || (!sq_tag.qzero && n1 <= 0 && n2 <= 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         s5_v_ff <= sq_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_n_ff    <= n_in;
         s5_miss_ff <= miss_in;
         s5_a_ff    <= sq_tag.a;
         s5_ray_ff  <= sq_tag.ray;
      end
   end

   // ---------------- D*n, three lanes ----------------
   logic                  mx_v, my_v, mz_v;
   mx_tag_type            mx_tag;
   logic signed [W-1:0]   my_tag;
   yz_type                mz_tag;
   logic signed [DNW-1:0] dnx, dny, dnz;

   rci_mul #(.WA(NW), .WB(W), .TW($bits(mx_tag_type))) u_mul_x (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s5_v_ff),
      .in_tag    ({s5_miss_ff, s5_a_ff}),
      .op_a      (s5_n_ff),
      .op_b      (s5_ray_ff.dx),
      .out_valid (mx_v),
      .out_tag   (mx_tag),
      .prod      (dnx)
   );

   rci_mul #(.WA(NW), .WB(W), .TW(W)) u_mul_y (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s5_v_ff),
      .in_tag    (s5_ray_ff.ox),
      .op_a      (s5_n_ff),
      .op_b      (s5_ray_ff.dy),
      .out_valid (my_v),
      .out_tag   (my_tag),
      .prod      (dny)
   );

   rci_mul #(.WA(NW), .WB(W), .TW($bits(yz_type))) u_mul_z (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s5_v_ff),
      .in_tag    ({s5_ray_ff.oy, s5_ray_ff.oz}),
      .op_a      (s5_n_ff),
      .op_b      (s5_ray_ff.dz),
      .out_valid (mz_v),
      .out_tag   (mz_tag),
      .prod      (dnz)
   );

   // ---------------- D*n / a, three lanes ----------------
   logic                  m2_v;
   logic                  dx_v, dy_v, dz_v;
   logic                  dx_tag;
   xy_type                dy_tag;
   logic signed [W-1:0]   dz_tag;
   logic signed [QTW-1:0] qx, qy, qz;

   assign m2_v = mx_v && my_v && mz_v;

   rci_div #(.NUMW(DNW), .DVW(DVW), .TW(1)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (m2_v),
      .in_tag    (mx_tag.miss),
      .numer     (dnx),
      .denom     (mx_tag.a[DVW-1:0]),
      .out_valid (dx_v),
      .out_tag   (dx_tag),
      .quot      (qx)
   );

   rci_div #(.NUMW(DNW), .DVW(DVW), .TW($bits(xy_type))) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (m2_v),
      .in_tag    ({my_tag, mz_tag.oy}),
      .numer     (dny),
      .denom     (mx_tag.a[DVW-1:0]),
      .out_valid (dy_v),
      .out_tag   (dy_tag),
      .quot      (qy)
   );

   rci_div #(.NUMW(DNW), .DVW(DVW), .TW(W)) u_div_z (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (m2_v),
      .in_tag    (mz_tag.oz),
      .numer     (dnz),
      .denom     (mx_tag.a[DVW-1:0]),
      .out_valid (dz_v),
      .out_tag   (dz_tag),
      .quot      (qz)
   );

   // ---------------- S6: hit point and z span ----------------
   logic                  s6_v_ff, s6_miss_ff, s6_zlo_ff, s6_zhi_ff;
   logic signed [PPW-1:0] s6_px_ff, s6_py_ff, s6_pz_ff;
   logic signed [PPW-1:0] pz_in;
   logic signed [ZW-1:0]  below_in, above_in;

   assign pz_in    = PPW'(dz_tag) + PPW'(qz);
   // Span test on the exact z, before saturation.
   assign below_in = ZW'(pz_in) - ZW'(bz_ff);
   assign above_in = ZW'(bz_ff) + $signed(ZW'(len_ff)) - ZW'(pz_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (adv) begin
         s6_v_ff <= dx_v && dy_v && dz_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_miss_ff <= dx_tag;
         s6_px_ff   <= PPW'(dy_tag.ox) + PPW'(qx);
         s6_py_ff   <= PPW'(dy_tag.oy) + PPW'(qy);
         s6_pz_ff   <= pz_in;
         s6_zlo_ff  <= below_in[ZW-1];
         s6_zhi_ff  <= above_in[ZW-1];
      end
   end

   // ---------------- output register ----------------
   logic                hit_in;
   logic                out_hit_ff;
   logic signed [W-1:0] out_x_ff, out_y_ff, out_z_ff;

   assign hit_in = !s6_miss_ff && !s6_zlo_ff && !s6_zhi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= s6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_hit_ff <= hit_in;
         out_x_ff   <= hit_in ? sat(s6_px_ff) : '0;
         out_y_ff   <= hit_in ? sat(s6_py_ff) : '0;
         out_z_ff   <= hit_in ? sat(s6_pz_ff) : '0;
      end
   end

   assign rsp.valid = out_v_ff;
   assign rsp.hit   = out_hit_ff;
   assign rsp.hit_x = out_x_ff;
   assign rsp.hit_y = out_y_ff;
   assign rsp.hit_z = out_z_ff;
endmodule
`default_nettype wire

// File: hw/rtl/rci_checker.sv
// Port-level checks for the intersection block, bound to the top level.
`default_nettype none
module rci_checker #(
   parameter int W = rci_pkg::COORD_WIDTH
) (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_hit,
   input logic signed [W-1:0] rsp_hit_x,
   input logic signed [W-1:0] rsp_hit_y,
   input logic signed [W-1:0] rsp_hit_z
);
   // A held response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_hit_x)
                                 && $stable(rsp_hit_y) && $stable(rsp_hit_z))
      else $error("response beat changed while stalled");

   // Request side backs off only when the output is blocked.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without output backpressure");

   // A miss carries a zero hit point.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_x == '0 && rsp_hit_y == '0 && rsp_hit_z == '0)
      else $error("miss with nonzero hit point");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind ray_cylinder_intersect rci_checker #(.W(COORD_WIDTH)) u_rci_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_hit   (rsp.hit),
   .rsp_hit_x (rsp.hit_x),
   .rsp_hit_y (rsp.hit_y),
   .rsp_hit_z (rsp.hit_z)
);
`default_nettype wire

// File: test/ray_cylinder_intersect_checker.sv
// Checker for the ray / cylinder block: predicts each response beat and compares it.
module ray_cylinder_intersect_checker
   import rci_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   rci_req_if                     req,
   rci_rsp_if                     rsp,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_idx,
   input  logic [COORD_WIDTH-1:0] csr_wdata,
   output int                     fail_count,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [191:0] wint_type;
   typedef struct packed {
      logic                         hit;
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } hit_type;

   logic signed [COORD_WIDTH-1:0] center_x, center_y, base_z;
   logic [COORD_WIDTH-2:0]        cyl_radius, cyl_length;
   hit_type                       hits_due[$];

   function automatic wint_type isqrt(wint_type v);
      logic [191:0] root, rem, trial;
      root = '0;
      rem  = '0;
      for (int p = 95; p >= 0; p--) begin
         rem   = (rem << 2) | v[2*p +: 2];
         trial = (root << 2) | 1;
         root  = root << 1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = root | 1;
         end
      end
      return wint_type'(root);
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] clamp(wint_type v);
      wint_type top_v, bot_v;
      top_v = (wint_type'(1) <<< (COORD_WIDTH-1)) - 1;
      bot_v = -(wint_type'(1) <<< (COORD_WIDTH-1));
      if (v > top_v) return top_v[COORD_WIDTH-1:0];
      if (v < bot_v) return bot_v[COORD_WIDTH-1:0];
      return v[COORD_WIDTH-1:0];
   endfunction

   function automatic hit_type trace_ray(logic signed [COORD_WIDTH-1:0] rox, roy, roz,
                                         logic signed [COORD_WIDTH-1:0] rdx, rdy, rdz);
      wint_type ox, oy, oz, dx, dy, dz, ex, ey, a, h, c, q, s, n, px, py, pz, bz, r, l;
      hit_type  res;
      res = '0;
      ox = wint_type'(rox); oy = wint_type'(roy); oz = wint_type'(roz);
      dx = wint_type'(rdx); dy = wint_type'(rdy); dz = wint_type'(rdz);
      bz = wint_type'(base_z);
      r  = wint_type'({1'b0, cyl_radius});
      l  = wint_type'({1'b0, cyl_length});
      if (dx == 0 && dy == 0) return res;
      ex = ox - wint_type'(center_x);
      ey = oy - wint_type'(center_y);
      a  = dx*dx + dy*dy;
      h  = dx*ex + dy*ey;
      c  = ex*ex + ey*ey - r*r;
      q  = h*h - a*c;
      if (q < 0) return res;
      if (q == 0) begin
         n = -h;               // tangent: no check that the point lies ahead
      end else begin
         s = isqrt(q);
         n = -h - s;
         if (n <= 0) begin
            n = -h + s;
            if (n <= 0) return res;
         end
      end
      px = ox + (dx*n) / a;
      py = oy + (dy*n) / a;
      pz = oz + (dz*n) / a;
      if (pz < bz || pz > bz + l) return res;
      res.hit = 1'b1;
      res.x   = clamp(px);
      res.y   = clamp(py);
      res.z   = clamp(pz);
      return res;
   endfunction

   task automatic report(string what, logic [COORD_WIDTH-1:0] got, logic [COORD_WIDTH-1:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      hit_type due;
      if (reset) begin
         center_x   <= '0;
         center_y   <= '0;
         base_z     <= '0;
         cyl_radius <= '0;
         cyl_length <= '0;
         hits_due.delete();
         pending    <= 0;
      end else begin
         if (req.valid && req.ready)
            hits_due.push_back(trace_ray(req.ray_origin_x, req.ray_origin_y, req.ray_origin_z,
                                         req.ray_dir_x, req.ray_dir_y, req.ray_dir_z));
         if (rsp.valid && rsp.ready) begin
            if (hits_due.size() == 0) begin
               report("unexpected beat", rsp.hit, '0);
            end else begin
               due = hits_due.pop_front();
               if (rsp.hit !== due.hit) report("hit", rsp.hit, due.hit);
               if (rsp.hit_x !== due.x) report("hit_x", rsp.hit_x, due.x);
               if (rsp.hit_y !== due.y) report("hit_y", rsp.hit_y, due.y);
               if (rsp.hit_z !== due.z) report("hit_z", rsp.hit_z, due.z);
            end
         end
         pending <= hits_due.size();
         if (csr_we) begin
            case (csr_idx)
               CSR_CENTER_X:   center_x   <= csr_wdata;
               CSR_CENTER_Y:   center_y   <= csr_wdata;
               CSR_BASE_Z:     base_z     <= csr_wdata;
               CSR_CYL_RADIUS: cyl_radius <= csr_wdata[COORD_WIDTH-2:0];
               CSR_CYL_LENGTH: cyl_length <= csr_wdata[COORD_WIDTH-2:0];
               default: ;
            endcase
         end
      end
   end

   initial fail_count = 0;
endmodule

// File: test/ray_cylinder_intersect_test.sv
// Top of the ray / cylinder testbench: clock, reset, stimulus and verdict.
module ray_cylinder_intersect_test;
   import rci_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ONE      = 1 << 16;   // 1.0 in Q16.16
   localparam int LATENCY  = 184;
   localparam int HOLD_LEN = 400;       // longer than the pipe, so input stalls
   localparam int WD_LIMIT = 20000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_idx = '0;
   logic [COORD_WIDTH-1:0] csr_wdata = '0;
   int                     fail_count, pending, idle_cycles;
   bit                     quiet = 0;     // no idling in the closing stretch
   bit                     hold_off = 0;  // request for one long rsp stall

   // cylinder as last written, used to aim rays
   int cyl_cx, cyl_cy, cyl_bz, cyl_r, cyl_len;

   rci_req_if req_ch ();
   rci_rsp_if rsp_ch ();

   ray_cylinder_intersect i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   ray_cylinder_intersect_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_we     (csr_we),
      .csr_idx    (csr_idx),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #4 clock = ~clock;

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.ray_origin_x = '0;
      req_ch.ray_origin_y = '0;
      req_ch.ray_origin_z = '0;
      req_ch.ray_dir_x    = '0;
      req_ch.ray_dir_y    = '0;
      req_ch.ray_dir_z    = '0;
      rsp_ch.ready        = 1'b0;
   end

   // Watchdog: any stretch with no beat on either side this long is a hang.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WD_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side back-pressure: random stall bursts, one long hold on request.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            hold_off = 0;
            rsp_ch.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Offer one ray and hold it until the beat goes through.
   task automatic send_ray(int ox, int oy, int oz, int dx, int dy, int dz);
      req_ch.ray_origin_x <= ox;
      req_ch.ray_origin_y <= oy;
      req_ch.ray_origin_z <= oz;
      req_ch.ray_dir_x    <= dx;
      req_ch.ray_dir_y    <= dy;
      req_ch.ray_dir_z    <= dz;
      req_ch.valid        <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      // random gap after the beat; valid drops only here, never re-raised this step
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Rewrite the whole cylinder; only called with the pipe empty.
   task automatic set_cylinder(int cx, int cy, int bz, int r, int len);
      logic [COORD_WIDTH-1:0] vals[5];
      logic [CSR_IDX_W-1:0]   idxs[5];
      vals = '{cx, cy, bz, r & 32'h7fff_ffff, len & 32'h7fff_ffff};
      idxs = '{CSR_CENTER_X, CSR_CENTER_Y, CSR_BASE_Z, CSR_CYL_RADIUS, CSR_CYL_LENGTH};
      csr_we <= 1'b1;
      foreach (vals[k]) begin
         csr_idx   <= idxs[k];
         csr_wdata <= vals[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      cyl_cx = cx; cyl_cy = cy; cyl_bz = bz; cyl_r = r; cyl_len = len;
   endtask

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
   endfunction

   // Ray from somewhere around the cylinder, aimed roughly at its axis.
   task automatic send_aimed_ray();
      longint span, offx, offy, oz, dx, dy;
      span = longint'(cyl_r) * 4 + ONE;
      offx = $signed(longint'($urandom_range(0, 2*span))) - span;
      offy = $signed(longint'($urandom_range(0, 2*span))) - span;
      oz   = longint'(cyl_bz) - cyl_len/2 + longint'($urandom_range(0, 2*cyl_len));
      dx   = -(offx >>> $urandom_range(0, 4)) + $signed($urandom_range(0, 2*ONE)) - ONE;
      dy   = -(offy >>> $urandom_range(0, 4)) + $signed($urandom_range(0, 2*ONE)) - ONE;
      send_ray(sat32(cyl_cx + offx), sat32(cyl_cy + offy), sat32(oz),
               sat32(dx), sat32(dy), $signed($urandom_range(0, 4*ONE)) - 2*ONE);
   endtask

   initial begin
      int hi, lo;
      hi = 32'h7fff_ffff;
      lo = 32'h8000_0000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: zero radius cylinder at the origin
      send_ray(-5*ONE, 0, 0, ONE, 0, 0);
      send_ray(0, 0, 0, ONE, ONE, 0);
      drain();

      // unit cylinder, z from 0 to 10
      set_cylinder(0, 0, 0, ONE, 10*ONE);
      send_ray(-5*ONE, 0, 5*ONE, ONE, 0, 0);         // straight hit on near side
      send_ray(-5*ONE, ONE, 5*ONE, ONE, 0, 0);       // tangent
      send_ray(5*ONE, ONE, 5*ONE, ONE, 0, 0);        // tangent, point behind origin
      send_ray(0, 0, 5*ONE, ONE, 0, 0);              // origin inside: far root
      send_ray(5*ONE, 0, 5*ONE, ONE, 0, 0);          // cylinder behind
      send_ray(-5*ONE, 3*ONE, 5*ONE, ONE, 0, 0);     // clean miss
      send_ray(0, 0, 5*ONE, 0, 0, ONE);              // no x/y direction
      send_ray(-5*ONE, 0, 5*ONE, ONE, 0, 4*ONE);     // leaves above the top
      send_ray(-5*ONE, 0, 5*ONE, ONE, 0, -4*ONE);    // leaves below the base
      send_ray(-5*ONE, 0, 0, ONE, 0, 0);             // exactly on the base
      send_ray(-5*ONE, 0, 10*ONE, ONE, 0, 0);        // exactly on the top
      send_ray(-5*ONE, 0, 5*ONE, 3, 0, 7);           // tiny direction, rounding
      send_ray(-5*ONE, 0, 5*ONE, hi, 1, lo);         // huge direction
      send_ray(hi, hi, hi, hi, hi, hi);
      send_ray(lo, lo, lo, lo, lo, lo);
      send_ray(lo, hi, 0, hi, lo, -1);
      drain();

      // extreme cylinder: far corner, full radius and length, saturating points
      set_cylinder(lo, hi, lo, hi, hi);
      send_ray(0, 0, 0, ONE, 0, 0);
      send_ray(hi, lo, hi, lo, hi, hi);
      send_ray(lo, hi, lo, hi, -ONE, hi);
      send_ray(0, 0, 0, 1, 1, lo);
      send_ray(-1, -1, -1, -1, -1, -1);
      drain();

      for (int i = 0; i < 1500; i++) begin
         if (i % 250 == 0) begin
            drain();
            case ((i / 250) % 3)
               0: set_cylinder($urandom_range(0, 64*ONE) - 32*ONE,
                               $urandom_range(0, 64*ONE) - 32*ONE,
                               $urandom_range(0, 64*ONE) - 32*ONE,
                               $urandom_range(ONE/4, 16*ONE), $urandom_range(0, 40*ONE));
               1: set_cylinder($urandom, $urandom, $urandom,
                               $urandom_range(1, 64*ONE), $urandom_range(0, 200*ONE));
               default: set_cylinder(hi - $urandom_range(0, 8*ONE),
                                     lo + $urandom_range(0, 8*ONE),
                                     $urandom_range(0, 4*ONE), $urandom_range(ONE, 4*ONE),
                                     $urandom_range(ONE, 8*ONE));
            endcase
         end
         if (i == 400) hold_off = 1;   // sender keeps offering through the stall
         if (i == 800) drain();        // let every result come home mid phase
         if (i == 1300) quiet = 1;
         if ($urandom_range(0, 4) == 0)
            send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         else
            send_aimed_ray();
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 16) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// File: ray_cylinder_intersect.f
hw/rtl/rci_pkg.sv
hw/rtl/rci_req_if.sv
hw/rtl/rci_rsp_if.sv
hw/rtl/rci_mul.sv
hw/rtl/rci_isqrt.sv
hw/rtl/rci_div.sv
hw/rtl/ray_cylinder_intersect.sv
hw/rtl/rci_checker.sv
test/ray_cylinder_intersect_checker.sv
test/ray_cylinder_intersect_test.sv
